### sv/tmn_pkg.sv
// Package of the trimmed-mean normalizer: constants, item structs and codes.
// Used by every module of the block; it depends on nothing.
package tmn_pkg;

  localparam int NUM_CHANNELS = 5;
  localparam int WINDOW       = 8;

  localparam int CHAN_W   = 3;
  localparam int SAMPLE_W = 8;
  localparam int PCT_W    = 7;
  localparam int FS_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_CFG  = 5;
  localparam logic [FS_W-1:0] FS_RESET = 16'd150;

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int SUM_W    = $clog2(WINDOW * 255 + 1);

  localparam int TRIM_DIV    = WINDOW - 2;
  localparam int LVL_DIV     = 5;
  localparam int RECIP_SHIFT = 16;
  localparam int MEAN_RECIP  = (1 << RECIP_SHIFT) / TRIM_DIV;
  localparam int LVL_RECIP   = (1 << RECIP_SHIFT) / LVL_DIV;

  localparam int NUM_W  = $clog2(LVL_DIV * 255 + 1);
  localparam int X_W    = (SUM_W > NUM_W) ? SUM_W : NUM_W;
  localparam int PROD_W = X_W + RECIP_SHIFT;

  localparam int PCT_MAX   = 100;
  localparam int PNUM_W    = $clog2(PCT_MAX * 255 + 1);
  localparam int TRIAL_W   = FS_W + PCT_W;
  localparam int BIT_IDX_W = $clog2(PCT_W);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [CHAN_W-1:0]   chan_in;
    logic [SAMPLE_W-1:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   chan_out;
    logic [SAMPLE_W-1:0] level;
    logic [PCT_W-1:0]    percent;
  } out_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [SUM_W-1:0]  trimmed;
  } win_item_t;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_MUL_MEAN = 7'b0000010,
    ST_FIX_MEAN = 7'b0000100,
    ST_MUL_LVL  = 7'b0001000,
    ST_FIX_LVL  = 7'b0010000,
    ST_DIV      = 7'b0100000,
    ST_DONE     = 7'b1000000
  } back_state_e;

endpackage

### sv/tmn_front.sv
// Front of the trimmed-mean normalizer: per-channel median of three and window sums.
// Depends on tmn_pkg; hands each completed window to the queue as a trimmed sum.
module tmn_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tmn_pkg::in_item_t  item_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output tmn_pkg::win_item_t q_item_o
);

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic [1:0]                   phase_q  [tmn_pkg::NUM_CHANNELS];
  logic [tmn_pkg::SAMPLE_W-1:0] first_q  [tmn_pkg::NUM_CHANNELS];
  logic [tmn_pkg::SAMPLE_W-1:0] second_q [tmn_pkg::NUM_CHANNELS];
  logic [tmn_pkg::CNT_W-1:0]    cnt_q    [tmn_pkg::NUM_CHANNELS];
  logic [tmn_pkg::SUM_W-1:0]    sum_q    [tmn_pkg::NUM_CHANNELS];
  logic [tmn_pkg::SAMPLE_W-1:0] min_q    [tmn_pkg::NUM_CHANNELS];
  logic [tmn_pkg::SAMPLE_W-1:0] max_q    [tmn_pkg::NUM_CHANNELS];

  logic                         accept;
  logic                         ch_ok;
  logic [tmn_pkg::CH_IDX_W-1:0] idx;
  logic [tmn_pkg::SAMPLE_W-1:0] a, b, c, lo, hi, med;
  logic [tmn_pkg::SAMPLE_W-1:0] min_new, max_new;
  logic [tmn_pkg::SUM_W-1:0]    sum_new;
  logic                         win_done;

  assign accept = push_i && !q_full_i;
  assign ch_ok  = {1'b0, item_i.chan_in} < (tmn_pkg::CHAN_W + 1)'(tmn_pkg::NUM_CHANNELS);
  assign idx    = item_i.chan_in[tmn_pkg::CH_IDX_W-1:0];

  always_comb begin
    a   = first_q[idx];
    b   = second_q[idx];
    c   = item_i.raw_sample;
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    if (c > hi) begin
      med = hi;
    end else if (c > lo) begin
      med = c;
    end else begin
      med = lo;
    end
    sum_new  = sum_q[idx] + tmn_pkg::SUM_W'(med);
    min_new  = (med < min_q[idx]) ? med : min_q[idx];
    max_new  = (med > max_q[idx]) ? med : max_q[idx];
    win_done = (cnt_q[idx] == tmn_pkg::CNT_W'(tmn_pkg::WINDOW - 1));
  end

  assign q_push_o         = accept && ch_ok && (phase_q[idx] == PH_THIRD) && win_done;
  assign q_item_o.chan    = item_i.chan_in;
  assign q_item_o.trimmed = sum_new - tmn_pkg::SUM_W'(min_new) - tmn_pkg::SUM_W'(max_new);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tmn_pkg::NUM_CHANNELS; i++) begin
        phase_q[i]  <= PH_FIRST;
        first_q[i]  <= '0;
        second_q[i] <= '0;
        cnt_q[i]    <= '0;
        sum_q[i]    <= '0;
        min_q[i]    <= '1;
        max_q[i]    <= '0;
      end
    end else if (accept && ch_ok) begin
      case (phase_q[idx])
        PH_FIRST: begin
          first_q[idx] <= item_i.raw_sample;
          phase_q[idx] <= PH_SECOND;
        end
        PH_SECOND: begin
          second_q[idx] <= item_i.raw_sample;
          phase_q[idx]  <= PH_THIRD;
        end
        default: begin
          phase_q[idx] <= PH_FIRST;
          if (win_done) begin
            cnt_q[idx] <= '0;
            sum_q[idx] <= '0;
            min_q[idx] <= '1;
            max_q[idx] <= '0;
          end else begin
            cnt_q[idx] <= cnt_q[idx] + 1'b1;
            sum_q[idx] <= sum_new;
            min_q[idx] <= min_new;
            max_q[idx] <= max_new;
          end
        end
      endcase
    end
  end

endmodule

### sv/tmn_fifo.sv
// Short queue of completed windows between the front and the back.
// Depends on tmn_pkg for the entry type and the depth.
module tmn_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  tmn_pkg::win_item_t wdata_i,
  input  logic               rd_i,
  output tmn_pkg::win_item_t rdata_o,
  output logic               full_o,
  output logic               empty_o
);

  tmn_pkg::win_item_t             mem_q [tmn_pkg::FIFO_DEPTH];
  logic [tmn_pkg::FIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [tmn_pkg::FIFO_CNT_W-1:0] cnt_q;
  logic                           do_wr, do_rd;

  assign full_o  = (cnt_q == tmn_pkg::FIFO_CNT_W'(tmn_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### sv/tmn_back.sv
// Back of the trimmed-mean normalizer: mean, smoothing, percent and the result register.
// Depends on tmn_pkg; holds the full-scale registers and the smoothed level of each channel.
module tmn_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  tmn_pkg::win_item_t            q_item_i,
  output logic                          q_pop_o,
  input  logic                          cfg_valid_i,
  input  logic [tmn_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tmn_pkg::FS_W-1:0]      cfg_data_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output tmn_pkg::out_item_t            out_item_o
);

  tmn_pkg::back_state_e state_q, state_d;

  logic [tmn_pkg::FS_W-1:0]      fs_q    [tmn_pkg::NUM_CFG];
  logic [tmn_pkg::SAMPLE_W-1:0]  level_q [tmn_pkg::NUM_CHANNELS];

  logic [tmn_pkg::CHAN_W-1:0]    chan_q;
  logic [tmn_pkg::X_W-1:0]       x_q;
  logic [tmn_pkg::PROD_W-1:0]    prod_q;
  logic [tmn_pkg::SAMPLE_W-1:0]  lvl_q;
  logic [tmn_pkg::PNUM_W-1:0]    rem_q;
  logic [tmn_pkg::FS_W-1:0]      div_fs_q;
  logic [tmn_pkg::PCT_W-1:0]     quo_q;
  logic [tmn_pkg::BIT_IDX_W-1:0] bit_q;
  logic                          sat_q;
  logic                          out_valid_q;
  tmn_pkg::out_item_t            out_q;

  logic [tmn_pkg::CH_IDX_W-1:0]  idx;
  logic [tmn_pkg::X_W-1:0]       q0, fix_rem, q_fixed;
  logic [tmn_pkg::X_W-1:0]       div_const;
  logic [tmn_pkg::SAMPLE_W-1:0]  q_byte;
  logic [tmn_pkg::FS_W-1:0]      fs_sel;
  logic [tmn_pkg::PNUM_W-1:0]    pnum;
  logic [tmn_pkg::TRIAL_W-1:0]   trial, fs_top;
  logic                          take;
  logic                          load_out;
  logic [tmn_pkg::PCT_W-1:0]     pct_final;

  assign idx     = chan_q[tmn_pkg::CH_IDX_W-1:0];
  assign take    = (state_q == tmn_pkg::ST_IDLE) && !q_empty_i;
  assign q_pop_o = take;

  always_comb begin
    div_const = (state_q == tmn_pkg::ST_FIX_MEAN) ? tmn_pkg::X_W'(tmn_pkg::TRIM_DIV)
                                                  : tmn_pkg::X_W'(tmn_pkg::LVL_DIV);
    q0      = tmn_pkg::X_W'(prod_q >> tmn_pkg::RECIP_SHIFT);
    fix_rem = x_q - tmn_pkg::X_W'(q0 * div_const);
    q_fixed = (fix_rem >= div_const) ? q0 + 1'b1 : q0;
    q_byte  = q_fixed[tmn_pkg::SAMPLE_W-1:0];
    if ({1'b0, chan_q} < (tmn_pkg::CHAN_W + 1)'(tmn_pkg::NUM_CFG)) begin
      fs_sel = fs_q[chan_q];
    end else begin
      fs_sel = tmn_pkg::FS_RESET;
    end
    pnum      = tmn_pkg::PNUM_W'(q_byte * tmn_pkg::PNUM_W'(tmn_pkg::PCT_MAX));
    fs_top    = {fs_sel, {tmn_pkg::PCT_W{1'b0}}};
    trial     = tmn_pkg::TRIAL_W'({div_fs_q, {tmn_pkg::PCT_W{1'b0}}} >>
                                  (tmn_pkg::PCT_W - int'(bit_q)));
    pct_final = (sat_q || quo_q > tmn_pkg::PCT_W'(tmn_pkg::PCT_MAX))
                ? tmn_pkg::PCT_W'(tmn_pkg::PCT_MAX) : quo_q;
    load_out  = (state_q == tmn_pkg::ST_DONE) && (!out_valid_q || pop_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tmn_pkg::ST_IDLE:     if (take) state_d = tmn_pkg::ST_MUL_MEAN;
      tmn_pkg::ST_MUL_MEAN: state_d = tmn_pkg::ST_FIX_MEAN;
      tmn_pkg::ST_FIX_MEAN: state_d = tmn_pkg::ST_MUL_LVL;
      tmn_pkg::ST_MUL_LVL:  state_d = tmn_pkg::ST_FIX_LVL;
      tmn_pkg::ST_FIX_LVL:  state_d = tmn_pkg::ST_DIV;
      tmn_pkg::ST_DIV:      if (sat_q || bit_q == '0) state_d = tmn_pkg::ST_DONE;
      tmn_pkg::ST_DONE:     if (load_out) state_d = tmn_pkg::ST_IDLE;
      default:              state_d = tmn_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tmn_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < tmn_pkg::NUM_CFG; i++) begin
        fs_q[i] <= tmn_pkg::FS_RESET;
      end
      for (int i = 0; i < tmn_pkg::NUM_CHANNELS; i++) begin
        level_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i &&
          {1'b0, cfg_index_i} < (tmn_pkg::CFG_IDX_W + 1)'(tmn_pkg::NUM_CFG)) begin
        fs_q[cfg_index_i] <= cfg_data_i;
      end
      if (state_q == tmn_pkg::ST_FIX_LVL) begin
        level_q[idx] <= q_byte;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      tmn_pkg::ST_IDLE: begin
        chan_q <= q_item_i.chan;
        x_q    <= tmn_pkg::X_W'(q_item_i.trimmed);
      end
      tmn_pkg::ST_MUL_MEAN: begin
        prod_q <= tmn_pkg::PROD_W'(x_q * tmn_pkg::PROD_W'(tmn_pkg::MEAN_RECIP));
      end
      tmn_pkg::ST_FIX_MEAN: begin
        x_q <= (tmn_pkg::X_W'(level_q[idx]) << 1) + tmn_pkg::X_W'(level_q[idx]) +
               (tmn_pkg::X_W'(q_byte) << 1);
      end
      tmn_pkg::ST_MUL_LVL: begin
        prod_q <= tmn_pkg::PROD_W'(x_q * tmn_pkg::PROD_W'(tmn_pkg::LVL_RECIP));
      end
      tmn_pkg::ST_FIX_LVL: begin
        lvl_q    <= q_byte;
        rem_q    <= pnum;
        div_fs_q <= fs_sel;
        quo_q    <= '0;
        bit_q    <= tmn_pkg::BIT_IDX_W'(tmn_pkg::PCT_W - 1);
        sat_q    <= (fs_sel == '0) || (tmn_pkg::TRIAL_W'(pnum) >= fs_top);
      end
      tmn_pkg::ST_DIV: begin
        if (tmn_pkg::TRIAL_W'(rem_q) >= trial) begin
          rem_q <= rem_q - tmn_pkg::PNUM_W'(trial);
          quo_q <= quo_q | (tmn_pkg::PCT_W'(1) << bit_q);
        end
        bit_q <= bit_q - 1'b1;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_q.chan_out <= chan_q;
      out_q.level    <= lvl_q;
      out_q.percent  <= pct_final;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

endmodule

### sv/adc_trimmed_mean_normalizer.sv
// Top level of the per-channel median-of-three trimmed-mean normalizer.
// Depends on tmn_pkg, tmn_front, tmn_fifo and tmn_back.
//
// Samples enter as items on a queue-style port: an item is taken at a clock
// edge with push high and full low, one item per cycle at full rate. Each
// channel groups its samples in threes, takes the median, and after a full
// window of medians emits one result with the smoothed level and its percent
// of the channel's full scale. Results leave on a second queue-style port:
// the oldest result is shown while empty is low and is taken with pop.
// A window goes from the queue through the back end's mean multiply and fix,
// level multiply and fix, seven-step percent division (cut short when the
// percent saturates at 100) and done state to the result register. The back
// end takes one window at a time; a four-entry queue of finished windows lets
// the front accept one item per cycle while the queue has room. If the receiver
// stalls, the result register holds, the queue fills, and full rises.
// Full-scale registers are written through the configuration channel, which
// is always ready; they reset to 150. Reset clears every channel's window,
// median phase and smoothed level, and empties the queue and result register.
module adc_trimmed_mean_normalizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  tmn_pkg::in_item_t             in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output tmn_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tmn_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tmn_pkg::FS_W-1:0]      cfg_data_i
);

  logic               q_wr, q_rd, q_full, q_empty;
  tmn_pkg::win_item_t q_wdata, q_rdata;

  assign full        = q_full;
  assign cfg_ready_o = 1'b1;

  tmn_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (in_item_i),
    .q_full_i (q_full),
    .q_push_o (q_wr),
    .q_item_o (q_wdata)
  );

  tmn_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  tmn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (q_rdata),
    .q_pop_o     (q_rd),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_item_o  (out_item_o)
  );

endmodule

### bench/tb_adc_trimmed_mean_normalizer.sv
// Self-checking testbench of adc_trimmed_mean_normalizer: directed and random samples
// go through its own per-channel predictor, and every result is compared with it.
// Depends on tmn_pkg and the adc_trimmed_mean_normalizer RTL.
module tb_adc_trimmed_mean_normalizer;

  localparam int NCH = tmn_pkg::NUM_CHANNELS;
  localparam int CHAN_SLOTS = 1 << tmn_pkg::CHAN_W;
  localparam int CFG_SLOTS = 1 << tmn_pkg::CFG_IDX_W;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  tmn_pkg::in_item_t in_item_i = '0;
  logic empty;
  logic pop = 1'b0;
  tmn_pkg::out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [tmn_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [tmn_pkg::FS_W-1:0] cfg_data_i = '0;

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int mismatch_cnt = 0;
  int quiet_cycles = 0;

  logic [tmn_pkg::FS_W-1:0] full_scale [NCH];
  logic [1:0] chan_phase [NCH];
  logic [tmn_pkg::SAMPLE_W-1:0] chan_first [NCH];
  logic [tmn_pkg::SAMPLE_W-1:0] chan_second [NCH];
  int win_count [NCH];
  int win_sum [NCH];
  logic [tmn_pkg::SAMPLE_W-1:0] win_lo [NCH];
  logic [tmn_pkg::SAMPLE_W-1:0] win_hi [NCH];
  logic [tmn_pkg::SAMPLE_W-1:0] chan_level [NCH];

  tmn_pkg::out_item_t pending_levels [$];

  adc_trimmed_mean_normalizer DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .in_item_i(in_item_i),
    .empty(empty),
    .pop(pop),
    .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_predictor();
    for (int c = 0; c < NCH; c++) begin
      full_scale[c] = tmn_pkg::FS_RESET;
      chan_phase[c] = 2'd0;
      chan_first[c] = '0;
      chan_second[c] = '0;
      chan_level[c] = '0;
      win_count[c] = 0;
      win_sum[c] = 0;
      win_lo[c] = 8'd255;
      win_hi[c] = 8'd0;
    end
  endfunction

  function automatic bit predict_level(input tmn_pkg::in_item_t it,
                                       output tmn_pkg::out_item_t res);
    int ch;
    logic [tmn_pkg::SAMPLE_W-1:0] a, b, s, lo, hi, med;
    int mean, lvl, pct;
    ch = int'(it.chan_in);
    s = it.raw_sample;
    res = '0;
    if (ch >= NCH) return 1'b0;
    if (chan_phase[ch] == 2'd0) begin
      chan_first[ch] = s;
      chan_phase[ch] = 2'd1;
      return 1'b0;
    end
    if (chan_phase[ch] == 2'd1) begin
      chan_second[ch] = s;
      chan_phase[ch] = 2'd2;
      return 1'b0;
    end
    chan_phase[ch] = 2'd0;
    a = chan_first[ch];
    b = chan_second[ch];
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    med = (s > hi) ? hi : ((s > lo) ? s : lo);
    win_sum[ch] += int'(med);
    if (med < win_lo[ch]) win_lo[ch] = med;
    if (med > win_hi[ch]) win_hi[ch] = med;
    win_count[ch]++;
    if (win_count[ch] < tmn_pkg::WINDOW) return 1'b0;
    mean = (win_sum[ch] - int'(win_lo[ch]) - int'(win_hi[ch])) / (tmn_pkg::WINDOW - 2);
    lvl = (3 * int'(chan_level[ch]) + 2 * mean) / 5;
    chan_level[ch] = lvl[tmn_pkg::SAMPLE_W-1:0];
    win_count[ch] = 0;
    win_sum[ch] = 0;
    win_lo[ch] = 8'd255;
    win_hi[ch] = 8'd0;
    if (full_scale[ch] == '0) begin
      pct = tmn_pkg::PCT_MAX;
    end else begin
      pct = (tmn_pkg::PCT_MAX * int'(chan_level[ch])) / int'(full_scale[ch]);
      if (pct > tmn_pkg::PCT_MAX) pct = tmn_pkg::PCT_MAX;
    end
    res.chan_out = ch[tmn_pkg::CHAN_W-1:0];
    res.level = chan_level[ch];
    res.percent = pct[tmn_pkg::PCT_W-1:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Entered and left at a falling edge; push stays high for back-to-back items.
  task automatic send_sample(input logic [tmn_pkg::CHAN_W-1:0] ch,
                             input logic [tmn_pkg::SAMPLE_W-1:0] raw);
    tmn_pkg::in_item_t it;
    tmn_pkg::out_item_t res;
    it.chan_in = ch;
    it.raw_sample = raw;
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push = 1'b1;
    in_item_i = it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (predict_level(it, res)) pending_levels.push_back(res);
    @(negedge clk_i);
  endtask

  task automatic write_full_scale(input logic [tmn_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [tmn_pkg::FS_W-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx < tmn_pkg::NUM_CFG) full_scale[idx] = val;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    push = 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [tmn_pkg::FS_W-1:0] pick_full_scale();
    case ($urandom_range(4))
      0: return '0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return tmn_pkg::FS_W'($urandom_range(300, 1));
      default: return tmn_pkg::FS_W'($urandom_range(65535, 1));
    endcase
  endfunction

  task automatic test_ignored_channels();
    send_sample(3'd5, 8'd255);
    send_sample(3'd6, 8'd0);
    send_sample(3'd7, 8'd170);
  endtask

  task automatic test_median_orders();
    int seq [24] = '{
      0, 255, 128,  255, 0, 128,  128, 0, 255,  0, 128, 255,
      255, 128, 0,  128, 255, 0,  255, 255, 255,  0, 0, 0};
    foreach (seq[i]) send_sample(tmn_pkg::CHAN_W'(NCH - 1), tmn_pkg::SAMPLE_W'(seq[i]));
    wait_drained();
  endtask

  task automatic test_config_registers();
    logic [tmn_pkg::FS_W-1:0] vals [tmn_pkg::NUM_CFG] =
      '{16'd0, 16'd1, 16'hFFFF, 16'd150, 16'd255};
    for (int i = 0; i < tmn_pkg::NUM_CFG; i++) begin
      write_full_scale(tmn_pkg::CFG_IDX_W'(i), vals[i]);
    end
    for (int i = tmn_pkg::NUM_CFG; i < CFG_SLOTS; i++) begin
      write_full_scale(tmn_pkg::CFG_IDX_W'(i), tmn_pkg::FS_W'($urandom_range(65535)));
    end
  endtask

  task automatic run_traffic(input int n_items);
    int sent;
    int mode;
    int reps;
    logic [tmn_pkg::CHAN_W-1:0] ch;
    logic [tmn_pkg::SAMPLE_W-1:0] base, v;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_sample(tmn_pkg::CHAN_W'($urandom_range(CHAN_SLOTS - 1, NCH)),
                    tmn_pkg::SAMPLE_W'($urandom_range(255)));
      end else begin
        ch = tmn_pkg::CHAN_W'($urandom_range(NCH - 1));
        mode = int'($urandom_range(3));
        base = tmn_pkg::SAMPLE_W'($urandom_range(255));
        reps = ($urandom_range(7) == 0) ? 1 : 3;
        repeat (reps) begin
          case (mode)
            0: v = tmn_pkg::SAMPLE_W'($urandom_range(255));
            1: v = tmn_pkg::SAMPLE_W'($urandom_range(255, 200));
            2: v = tmn_pkg::SAMPLE_W'($urandom_range(40));
            default: v = base;
          endcase
          send_sample(ch, v);
          sent++;
        end
      end
    end
  endtask

  task automatic test_idle_phases();
    int sidle [4] = '{0, 49, 0, 8};
    int pstall [4] = '{0, 0, 49, 8};
    for (int p = 0; p < 4; p++) begin
      if (p != 0) begin
        wait_drained();
        for (int i = 0; i < tmn_pkg::NUM_CFG; i++) begin
          write_full_scale(tmn_pkg::CFG_IDX_W'(i), pick_full_scale());
        end
      end
      send_idle_pct = sidle[p];
      pop_stall_pct = pstall[p];
      run_traffic(225);
    end
    wait_drained();
  endtask

  always @(negedge clk_i) pop <= ($urandom_range(99) >= pop_stall_pct);

  always @(posedge clk_i) begin
    tmn_pkg::out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_levels.size() == 0) begin
        report_mismatch("result with nothing pending, chan", int'(out_item_o.chan_out), -1);
      end else begin
        want = pending_levels.pop_front();
        if (out_item_o.chan_out !== want.chan_out)
          report_mismatch("chan_out", int'(out_item_o.chan_out), int'(want.chan_out));
        if (out_item_o.level !== want.level)
          report_mismatch("level", int'(out_item_o.level), int'(want.level));
        if (out_item_o.percent !== want.percent)
          report_mismatch("percent", int'(out_item_o.percent), int'(want.percent));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    clear_predictor();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_ignored_channels();
    test_median_orders();
    test_config_registers();
    test_idle_phases();
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
sv/tmn_pkg.sv
sv/tmn_front.sv
sv/tmn_fifo.sv
sv/tmn_back.sv
sv/adc_trimmed_mean_normalizer.sv
bench/tb_adc_trimmed_mean_normalizer.sv
